@@ rtl/core/mandelbrot_pixel_iterator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot pixel iterator
// Each check is a clocked property on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_PIXEL_ITERATOR_ASSERT_SVH
`define MANDELBROT_PIXEL_ITERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define MPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpi: same-cycle check failed");
`define MPI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpi: next-cycle check failed");
`else
`define MPI_ASSERT_IMP(label, ante, cons)
`define MPI_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ rtl/core/mpi_pkg.sv @@
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared types, constants and helpers of the Mandelbrot pixel iterator.
// ----------------------------------------------------------------------------
package mpi_pkg;

  localparam int FRAC_BITS_DEF  = 24;
  localparam int PIXEL_BITS_DEF = 12;

  localparam int COORD_W     = 32;
  localparam int STEP_W      = 31;
  localparam int COUNT_W     = 16;
  localparam int MAG_W       = 48;
  localparam int ACC_W       = 52;
  localparam int PROD_W      = 64;
  localparam int ROOT_W      = 32;
  localparam int SQRT_STEPS  = 32;
  localparam int SQRT_CNT_W  = 5;
  localparam int SQ_REM_W    = 35;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_PAD_W   = 7;
  localparam int OUT_DATA_W  = 136;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd33554432;
  localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd16575889;
  localparam logic [STEP_W-1:0]         X_STEP_RST   = 31'd26214;
  localparam logic [STEP_W-1:0]         Y_STEP_RST   = 31'd26214;
  localparam logic [COUNT_W-1:0]        ITER_LIM_RST = 16'd1000;
  localparam logic [COUNT_W-1:0]        BAILOUT_RST  = 16'd4;
  localparam logic signed [COORD_W-1:0] TRAP_X_RST   = -32'sd12163481;
  localparam logic signed [COORD_W-1:0] TRAP_Y_RST   = 32'sd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_ORIGIN,
    REG_Y_ORIGIN,
    REG_X_STEP,
    REG_Y_STEP,
    REG_ITER_LIMIT,
    REG_BAILOUT,
    REG_TRAP_X,
    REG_TRAP_Y
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_origin;
    logic [STEP_W-1:0]         x_step;
    logic [STEP_W-1:0]         y_step;
    logic [COUNT_W-1:0]        iteration_limit;
    logic [COUNT_W-1:0]        bailout;
    logic signed [COORD_W-1:0] trap_x;
    logic signed [COORD_W-1:0] trap_y;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p;
    logic signed [COORD_W-1:0] q;
  } coord_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iterations;
    logic               escaped;
    logic [MAG_W-1:0]   final_mag_sq;
    logic [COORD_W-1:0] final_diag_abs;
    logic [PROD_W-1:0]  trap_min_sq;
  } iter_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iterations;
    logic               escaped;
    logic [MAG_W-1:0]   final_mag_sq;
    logic [COORD_W-1:0] final_diag_abs;
    logic [ROOT_W-1:0]  trap_min_dist;
  } pix_res_t;

  typedef enum logic [2:0] {
    CORE_IDLE,
    CORE_ADD,
    CORE_DIFF,
    CORE_MUL,
    CORE_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_HOLD
  } sqrt_state_t;

  function automatic logic signed [COORD_W-1:0] sat_s32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-COORD_W:0] top;
    top = v[ACC_W-1:COORD_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[COORD_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  function automatic logic [MAG_W-1:0] sat_mag(input logic [MAG_W:0] v);
    return v[MAG_W] ? MAG_MAX : v[MAG_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] abs32(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  function automatic logic [COORD_W:0] abs33(input logic signed [COORD_W:0] v);
    return v[COORD_W] ? (COORD_W+1)'(-v) : (COORD_W+1)'(v);
  endfunction

endpackage

@@ rtl/core/mandelbrot_pixel_iterator.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator
// Escape-time Mandelbrot pixel engine with orbit trap, Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the eight registers through cfg_we/cfg_addr/cfg_wdata while
//   the block is idle; reset loads the default view and trap point.
//   Each s_tdata request carries one pixel (x, y); each m_tdata request
//   returns its iteration count, escape flag, final |z|^2, final |re+im|
//   and the minimum distance to the trap point.
//   Front: a multiply register and an add-and-saturate register map the
//   pixel to c, then a two-entry queue. Core: each iteration passes through
//   the add, difference and multiply states; the default limit is 1000.
//   Root: digit-by-digit square root of the trap distance, overlapped with
//   the next pixel. The core holds one pixel at a time; the front and queue
//   take new pixels while it iterates, until they are full.
//   A stalled m_tready holds the output register; the root unit, core,
//   queue and front then fill in turn before s_tready drops.
//   Reset empties every stage; no item is in flight afterward.
// ----------------------------------------------------------------------------
`include "mandelbrot_pixel_iterator_assert.svh"

module mandelbrot_pixel_iterator #(
  parameter int FRAC_BITS  = mpi_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = mpi_pkg::PIXEL_BITS_DEF,
  parameter int IN_DATA_W  = ((2 * PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // pixel_x, pixel_y
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [IN_DATA_W-1:0]           s_tdata,
  // iterations, escaped, final_mag_sq, final_diag_abs, trap_min_dist
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mpi_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [mpi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mpi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mpi_pkg::*;

  cfg_t      cfg;
  logic      fr_valid;
  logic      fr_ready;
  coord_t    fr_coord;
  logic      qu_valid;
  logic      qu_ready;
  coord_t    qu_coord;
  logic      core_valid;
  logic      sq_in_ready;
  iter_res_t core_res;
  logic      sq_valid;
  logic      sq_ready;
  pix_res_t  sq_res;
  pix_res_t  out_res;
  logic      out_defaults;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin        <= X_ORIGIN_RST;
      cfg.y_origin        <= Y_ORIGIN_RST;
      cfg.x_step          <= X_STEP_RST;
      cfg.y_step          <= Y_STEP_RST;
      cfg.iteration_limit <= ITER_LIM_RST;
      cfg.bailout         <= BAILOUT_RST;
      cfg.trap_x          <= TRAP_X_RST;
      cfg.trap_y          <= TRAP_Y_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_X_ORIGIN:   cfg.x_origin        <= cfg_wdata;
        REG_Y_ORIGIN:   cfg.y_origin        <= cfg_wdata;
        REG_X_STEP:     cfg.x_step          <= cfg_wdata[STEP_W-1:0];
        REG_Y_STEP:     cfg.y_step          <= cfg_wdata[STEP_W-1:0];
        REG_ITER_LIMIT: cfg.iteration_limit <= cfg_wdata[COUNT_W-1:0];
        REG_BAILOUT:    cfg.bailout         <= cfg_wdata[COUNT_W-1:0];
        REG_TRAP_X:     cfg.trap_x          <= cfg_wdata;
        REG_TRAP_Y:     cfg.trap_y          <= cfg_wdata;
      endcase
    end
  end

  mpi_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pixel_x   (s_tdata[PIXEL_BITS-1:0]),
    .pixel_y   (s_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_coord (fr_coord)
  );

  mpi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_coord  (fr_coord),
    .out_valid (qu_valid),
    .out_ready (qu_ready),
    .out_coord (qu_coord)
  );

  mpi_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (qu_valid),
    .in_ready  (qu_ready),
    .in_coord  (qu_coord),
    .out_valid (core_valid),
    .out_ready (sq_in_ready),
    .out_res   (core_res)
  );

  mpi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (core_valid),
    .in_ready  (sq_in_ready),
    .in_res    (core_res),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_res   (sq_res)
  );

  assign sq_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sq_ready) begin
      m_tvalid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid && sq_ready) begin
      out_res <= sq_res;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res.trap_min_dist, out_res.final_diag_abs,
                    out_res.final_mag_sq, out_res.escaped, out_res.iterations};

  assign out_defaults = (out_res.final_mag_sq == '0) && (out_res.final_diag_abs == '0) &&
                        (out_res.trap_min_dist == '1);

  `MPI_ASSERT_IMP(a_escape_needs_iter, m_tvalid && out_res.escaped, out_res.iterations != '0)
  `MPI_ASSERT_IMP(a_no_iter_defaults, m_tvalid && (out_res.iterations == '0), out_defaults)
  `MPI_ASSERT_NXT(a_root_starts, core_valid && sq_in_ready, !sq_in_ready)

endmodule

@@ rtl/core/mpi_queue.sv @@
// ----------------------------------------------------------------------------
// mpi_queue
// Short FIFO of mapped points between the setup front and the iteration core.
// ----------------------------------------------------------------------------
module mpi_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mpi_pkg::coord_t in_coord,
  output logic            out_valid,
  input  logic            out_ready,
  output mpi_pkg::coord_t out_coord
);
  import mpi_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  coord_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_coord = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_coord;
    end
  end

endmodule

@@ rtl/core/mpi_front.sv @@
// ----------------------------------------------------------------------------
// mpi_front
// Pixel intake: scale the pixel indices by the step, add the origin, saturate.
// ----------------------------------------------------------------------------
module mpi_front #(
  parameter int PIXEL_BITS = mpi_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mpi_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] pixel_x,
  input  logic [PIXEL_BITS-1:0] pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mpi_pkg::coord_t       out_coord
);
  import mpi_pkg::*;

  localparam int MULT_W = PIXEL_BITS + STEP_W;

  logic              v1;
  logic              v2;
  logic              adv1;
  logic              adv2;
  logic [MULT_W-1:0] mx;
  logic [MULT_W-1:0] my;
  logic signed [ACC_W-1:0] sum_x;
  logic signed [ACC_W-1:0] sum_y;

  assign adv2      = !v2 || out_ready;
  assign adv1      = !v1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = v2;

  assign sum_x = ACC_W'(cfg.x_origin) + ACC_W'(mx);
  assign sum_y = ACC_W'(cfg.y_origin) + ACC_W'(my);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      mx <= MULT_W'(pixel_x) * MULT_W'(cfg.x_step);
      my <= MULT_W'(pixel_y) * MULT_W'(cfg.y_step);
    end
    if (adv2 && v1) begin
      out_coord.p <= sat_s32(sum_x);
      out_coord.q <= sat_s32(sum_y);
    end
  end

endmodule

@@ rtl/core/mpi_core.sv @@
// ----------------------------------------------------------------------------
// mpi_core
// Escape-time engine: three-square iteration, bailout test, trap tracking.
// ----------------------------------------------------------------------------
module mpi_core #(
  parameter int FRAC_BITS = mpi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mpi_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpi_pkg::coord_t    in_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output mpi_pkg::iter_res_t out_res
);
  import mpi_pkg::*;

  core_state_t state;
  core_state_t state_next;

  logic signed [COORD_W-1:0] p;
  logic signed [COORD_W-1:0] q;
  logic signed [COORD_W-1:0] x1;
  logic signed [COORD_W-1:0] y1;
  logic [COORD_W-1:0] ax1;
  logic [COORD_W-1:0] ay1;
  logic [COORD_W-1:0] diag;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [PROD_W-1:0]  px2;
  logic [PROD_W-1:0]  py2;
  logic [PROD_W-1:0]  pw;
  logic [PROD_W-1:0]  pdx;
  logic [PROD_W-1:0]  pdy;
  logic [PROD_W-1:0]  trap_min;
  logic [COUNT_W-1:0] iter_cnt;
  logic [MAG_W-1:0]   mag;
  logic               first;
  logic               escaped;

  logic [MAG_W-1:0]   x2_r;
  logic [MAG_W-1:0]   y2_r;
  logic [MAG_W-1:0]   w_r;
  logic [MAG_W-1:0]   mag_r;
  logic [MAG_W-1:0]   thr;
  logic [PROD_W-1:0]  thr_ext;
  logic [PROD_W:0]    trap_sum_w;
  logic [PROD_W-1:0]  trap_sum;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic [COORD_W:0]   diag_a;
  logic [COORD_W:0]   dx_a;
  logic [COORD_W:0]   dy_a;
  logic               go;

  function automatic logic [MAG_W-1:0] sq_scale(input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] sh;
    sh = prod >> FRAC_BITS;
    return (|sh[PROD_W-1:MAG_W]) ? MAG_MAX : sh[MAG_W-1:0];
  endfunction

  assign x2_r  = sq_scale(px2);
  assign y2_r  = sq_scale(py2);
  assign w_r   = sq_scale(pw);
  assign mag_r = sat_mag({1'b0, x2_r} + {1'b0, y2_r});

  assign thr_ext = PROD_W'(cfg.bailout) << FRAC_BITS;
  assign thr     = (|thr_ext[PROD_W-1:MAG_W]) ? MAG_MAX : thr_ext[MAG_W-1:0];
  assign go      = (mag_r <= thr) && (iter_cnt < cfg.iteration_limit);

  assign acc_x = ACC_W'(x2_r) - ACC_W'(y2_r) + ACC_W'(p);
  assign acc_y = ACC_W'(w_r) - ACC_W'(x2_r) - ACC_W'(y2_r) + ACC_W'(q);

  assign trap_sum_w = {1'b0, pdx} + {1'b0, pdy};
  assign trap_sum   = trap_sum_w[PROD_W] ? '1 : trap_sum_w[PROD_W-1:0];

  assign diag_a = abs33((COORD_W+1)'(x1) + (COORD_W+1)'(y1));
  assign dx_a   = abs33((COORD_W+1)'(x1) - (COORD_W+1)'(cfg.trap_x));
  assign dy_a   = abs33((COORD_W+1)'(y1) - (COORD_W+1)'(cfg.trap_y));

  assign out_res.iterations     = iter_cnt;
  assign out_res.escaped        = escaped;
  assign out_res.final_mag_sq   = mag;
  assign out_res.final_diag_abs = diag;
  assign out_res.trap_min_sq    = trap_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      CORE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = CORE_ADD;
        end
      end
      CORE_ADD: begin
        state_next = go ? CORE_DIFF : CORE_DONE;
      end
      CORE_DIFF: begin
        state_next = CORE_MUL;
      end
      CORE_MUL: begin
        state_next = CORE_ADD;
      end
      CORE_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = CORE_IDLE;
        end
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == CORE_IDLE) && in_valid) begin
      p        <= in_coord.p;
      q        <= in_coord.q;
      px2      <= '0;
      py2      <= '0;
      pw       <= '0;
      pdx      <= '0;
      pdy      <= '0;
      iter_cnt <= '0;
      diag     <= '0;
      trap_min <= '1;
      first    <= 1'b1;
    end
    if (state == CORE_ADD) begin
      first <= 1'b0;
      if (!first && (trap_sum < trap_min)) begin
        trap_min <= trap_sum;
      end
      if (go) begin
        x1       <= sat_s32(acc_x);
        y1       <= sat_s32(acc_y);
        iter_cnt <= iter_cnt + 1'b1;
      end else begin
        mag     <= mag_r;
        escaped <= (iter_cnt < cfg.iteration_limit);
      end
    end
    if (state == CORE_DIFF) begin
      diag <= diag_a[COORD_W] ? '1 : diag_a[COORD_W-1:0];
      ax1  <= abs32(x1);
      ay1  <= abs32(y1);
      dx   <= dx_a[COORD_W-1:0];
      dy   <= dy_a[COORD_W-1:0];
    end
    if (state == CORE_MUL) begin
      px2 <= PROD_W'(ax1) * PROD_W'(ax1);
      py2 <= PROD_W'(ay1) * PROD_W'(ay1);
      pw  <= PROD_W'(diag) * PROD_W'(diag);
      pdx <= PROD_W'(dx) * PROD_W'(dx);
      pdy <= PROD_W'(dy) * PROD_W'(dy);
    end
  end

endmodule

@@ rtl/core/mpi_sqrt.sv @@
// ----------------------------------------------------------------------------
// mpi_sqrt
// Digit-by-digit integer square root of the smallest squared trap distance.
// ----------------------------------------------------------------------------
module mpi_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpi_pkg::iter_res_t in_res,
  output logic               out_valid,
  input  logic               out_ready,
  output mpi_pkg::pix_res_t  out_res
);
  import mpi_pkg::*;

  sqrt_state_t state;
  sqrt_state_t state_next;

  logic [PROD_W-1:0]     rad;
  logic [SQ_REM_W-1:0]   rem;
  logic [ROOT_W-1:0]     root;
  logic [SQRT_CNT_W-1:0] cnt;
  iter_res_t             hold;

  logic [SQ_REM_W-1:0]   rem_sh;
  logic [SQ_REM_W-1:0]   trial;
  logic                  take;

  assign rem_sh = {rem[SQ_REM_W-3:0], rad[PROD_W-1:PROD_W-2]};
  assign trial  = SQ_REM_W'({root, 2'b01});
  assign take   = (rem_sh >= trial);

  assign out_res.iterations     = hold.iterations;
  assign out_res.escaped        = hold.escaped;
  assign out_res.final_mag_sq   = hold.final_mag_sq;
  assign out_res.final_diag_abs = hold.final_diag_abs;
  assign out_res.trap_min_dist  = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      SQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (cnt == '0) begin
          state_next = SQ_HOLD;
        end
      end
      SQ_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = SQ_IDLE;
        end
      end
      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == SQ_IDLE) && in_valid) begin
      rad  <= in_res.trap_min_sq;
      rem  <= '0;
      root <= '0;
      cnt  <= SQRT_CNT_W'(SQRT_STEPS - 1);
      hold <= in_res;
    end
    if (state == SQ_RUN) begin
      rad  <= {rad[PROD_W-3:0], 2'b00};
      root <= {root[ROOT_W-2:0], take};
      rem  <= take ? (rem_sh - trial) : rem_sh;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

@@ test/mandelbrot_pixel_iterator_test.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator_test
// Drives pixel requests into the Mandelbrot iterator under a series of views,
// predicts each escape count, escape flag, final |z|^2, final |re+im| and
// trap distance in fixed point, and compares every returned request field by
// field. Both stream sides idle in random bursts; a long output hold-off
// fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_iterator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpi_pkg::*;

  localparam int     PIX_W          = PIXEL_BITS_DEF;
  localparam int     IN_W           = ((2 * PIX_W + 7) / 8) * 8;
  localparam int     FRAC           = FRAC_BITS_DEF;
  localparam longint Q_MAX          = 64'sd2147483647;
  localparam longint Q_MIN          = -64'sd2147483648;
  localparam longint ONE_Q          = 64'sd1 << FRAC;
  localparam int     WATCHDOG_LIMIT = 800000;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [ROOT_W-1:0]    trap_min_dist;
    logic [COORD_W-1:0]   final_diag_abs;
    logic [MAG_W-1:0]     final_mag_sq;
    logic                 escaped;
    logic [COUNT_W-1:0]   iterations;
  } out_word_t;

  typedef struct {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    pix_res_t         want;
  } pixel_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cfg_t           view;
  pixel_outcome_t pending_pixels[$];
  pixel_outcome_t oldest;
  out_word_t      seen;
  int             mismatches = 0;
  int             quiet_cycles = 0;
  int             receiver_hold = 0;
  bit             idling = 1'b0;

  mandelbrot_pixel_iterator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  function automatic longint clamp_q824(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [31:0] floor_root(bit [63:0] v);
    bit [31:0] r;
    bit [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {32'd0, r | (32'd1 << b)};
      if (t * t <= v) r = t[31:0];
    end
    return r;
  endfunction

  function automatic pix_res_t predict_pixel(cfg_t v, logic [PIX_W-1:0] px,
                                             logic [PIX_W-1:0] py);
    longint      c_re, c_im, re, im, sq_re, sq_im, sq_diag, mag, thr;
    longint      trap_re, trap_im;
    bit [63:0]   diag, mre, mim, dx, dy, dist_sq, best_sq;
    bit [64:0]   sum;
    int unsigned count;
    pix_res_t    r;
    c_re    = clamp_q824(longint'($signed(v.x_origin)) + longint'(px) * longint'(v.x_step));
    c_im    = clamp_q824(longint'($signed(v.y_origin)) + longint'(py) * longint'(v.y_step));
    trap_re = longint'($signed(v.trap_x));
    trap_im = longint'($signed(v.trap_y));
    thr     = longint'(v.bailout) << FRAC;
    sq_re   = 0;
    sq_im   = 0;
    sq_diag = 0;
    mag     = 0;
    diag    = '0;
    best_sq = '1;
    count   = 0;
    while (mag <= thr && count < v.iteration_limit) begin
      re   = clamp_q824(sq_re - sq_im + c_re);
      im   = clamp_q824(sq_diag - sq_re - sq_im + c_im);
      diag = magnitude(re + im);
      if (diag > 64'hFFFF_FFFF) diag = 64'hFFFF_FFFF;
      mre     = magnitude(re);
      mim     = magnitude(im);
      sq_re   = longint'((mre * mre) >> FRAC);
      sq_im   = longint'((mim * mim) >> FRAC);
      sq_diag = longint'((diag * diag) >> FRAC);
      mag     = sq_re + sq_im;
      dx      = magnitude(re - trap_re);
      dy      = magnitude(im - trap_im);
      sum     = {1'b0, dx * dx} + {1'b0, dy * dy};
      dist_sq = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      if (dist_sq < best_sq) best_sq = dist_sq;
      count++;
    end
    r.iterations     = count[COUNT_W-1:0];
    r.escaped        = (count < v.iteration_limit);
    r.final_mag_sq   = mag[MAG_W-1:0];
    r.final_diag_abs = diag[COORD_W-1:0];
    r.trap_min_dist  = floor_root(best_sq);
    return r;
  endfunction

  function automatic cfg_t reset_view();
    return '{x_origin: X_ORIGIN_RST, y_origin: Y_ORIGIN_RST, x_step: X_STEP_RST,
             y_step: Y_STEP_RST, iteration_limit: ITER_LIM_RST, bailout: BAILOUT_RST,
             trap_x: TRAP_X_RST, trap_y: TRAP_Y_RST};
  endfunction

  function automatic cfg_t random_view(logic [COUNT_W-1:0] limit, bit wild);
    cfg_t v;
    v.x_origin = wild ? $urandom : int'($urandom_range(0, 58720256)) - 41943040;
    v.y_origin = wild ? $urandom : int'($urandom_range(0, 33554432)) - 25165824;
    v.x_step   = STEP_W'(wild ? $urandom : $urandom_range(1, 16384));
    v.y_step   = STEP_W'(wild ? $urandom : $urandom_range(1, 16384));
    v.iteration_limit = limit;
    v.bailout  = COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) :
                                                         $urandom_range(1, 8));
    v.trap_x   = wild ? $urandom : int'($urandom_range(0, 33554432)) - 16777216;
    v.trap_y   = wild ? $urandom : int'($urandom_range(0, 33554432)) - 16777216;
    return v;
  endfunction

  task automatic report_mismatch(string line);
    $display("ERROR: %s", line);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("pixel (%0d,%0d) %s got 0x%0h want 0x%0h",
                                oldest.px, oldest.py, name, got, want));
  endtask

  task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic write_view(cfg_t v);
    put_reg(REG_X_ORIGIN, v.x_origin);
    put_reg(REG_Y_ORIGIN, v.y_origin);
    put_reg(REG_X_STEP, {1'b0, v.x_step});
    put_reg(REG_Y_STEP, {1'b0, v.y_step});
    put_reg(REG_ITER_LIMIT, {16'd0, v.iteration_limit});
    put_reg(REG_BAILOUT, {16'd0, v.bailout});
    put_reg(REG_TRAP_X, v.trap_x);
    put_reg(REG_TRAP_Y, v.trap_y);
    cfg_we <= 1'b0;
    view = v;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    pixel_outcome_t job;
    if (idling && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {py, px};
    do @(posedge clk); while (!s_tready);
    job.px   = px;
    job.py   = py;
    job.want = predict_pixel(view, px, py);
    pending_pixels.insert(pending_pixels.size(), job);
  endtask

  task automatic finish_pending();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1280, 12'd632);
    send_pixel(12'd960, 12'd632);
    finish_pending();
  endtask

  task automatic test_register_extremes();
    write_view('{x_origin: 32'sh8000_0000, y_origin: 32'sh7FFF_FFFF,
                 x_step: 31'h7FFF_FFFF, y_step: 31'h7FFF_FFFF, iteration_limit: 16'd20,
                 bailout: 16'hFFFF, trap_x: 32'sh7FFF_FFFF, trap_y: 32'sh8000_0000});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    finish_pending();
    write_view('{x_origin: 32'sh7FFF_FFFF, y_origin: 32'sh8000_0000, x_step: 31'd0,
                 y_step: 31'd0, iteration_limit: 16'd1, bailout: 16'd1,
                 trap_x: 32'sh8000_0000, trap_y: 32'sh7FFF_FFFF});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2730, 12'd1365);
    finish_pending();
  endtask

  task automatic test_zero_limit_and_bailout();
    cfg_t v;
    v = reset_view();
    v.iteration_limit = 16'd0;
    write_view(v);
    send_pixel(12'd1280, 12'd632);
    finish_pending();
    v = '{x_origin: 32'sd0, y_origin: 32'sd0, x_step: 31'd4194304, y_step: 31'd0,
          iteration_limit: 16'd50, bailout: 16'd0, trap_x: 32'sd0, trap_y: 32'sd0};
    write_view(v);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    finish_pending();
  endtask

  task automatic test_last_iteration_escape();
    cfg_t v;
    v = '{x_origin: 32'(ONE_Q), y_origin: 32'sd0, x_step: 31'd0, y_step: 31'd0,
          iteration_limit: 16'd3, bailout: 16'd4, trap_x: TRAP_X_RST, trap_y: TRAP_Y_RST};
    write_view(v);
    send_pixel(12'd0, 12'd0);
    finish_pending();
    v.iteration_limit = 16'd4;
    write_view(v);
    send_pixel(12'd0, 12'd0);
    finish_pending();
  endtask

  task automatic test_deep_orbit();
    write_view('{x_origin: 32'sd0, y_origin: 32'sd0, x_step: 31'd0, y_step: 31'd0,
                 iteration_limit: 16'hFFFF, bailout: 16'd4, trap_x: 32'sd0,
                 trap_y: 32'sd0});
    send_pixel(12'd4095, 12'd4095);
    finish_pending();
  endtask

  task automatic test_output_backpressure();
    cfg_t v;
    bit   was_idling;
    v = reset_view();
    v.iteration_limit = 16'd8;
    write_view(v);
    was_idling    = idling;
    idling        = 1'b0;
    receiver_hold = 3000;
    repeat (12) send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
    finish_pending();
    idling = was_idling;
  endtask

  task automatic test_sender_pause();
    cfg_t v;
    v = reset_view();
    v.iteration_limit = 16'd24;
    write_view(v);
    repeat (8) send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
    finish_pending();
    repeat (8) send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
    finish_pending();
  endtask

  task automatic test_random_views(int phases, int per_phase, bit allow_idle);
    logic [COUNT_W-1:0] limit;
    for (int phase = 0; phase < phases; phase++) begin
      if (phase == 2) limit = 16'd1000;
      else if (phase == 6) limit = COUNT_W'($urandom_range(100, 300));
      else limit = COUNT_W'($urandom_range(1, 64));
      write_view(random_view(limit, $urandom_range(0, 3) == 0));
      idling = allow_idle && ($urandom_range(0, 3) != 0);
      repeat (per_phase)
        send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
      finish_pending();
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (receiver_hold > 0) begin
        receiver_hold--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result with no pixel pending, iterations %0d",
                                  seen.iterations));
      end else begin
        oldest = pending_pixels.pop_front();
        compare_field("iterations", 64'(seen.iterations), 64'(oldest.want.iterations));
        compare_field("escaped", 64'(seen.escaped), 64'(oldest.want.escaped));
        compare_field("final_mag_sq", 64'(seen.final_mag_sq),
                      64'(oldest.want.final_mag_sq));
        compare_field("final_diag_abs", 64'(seen.final_diag_abs),
                      64'(oldest.want.final_diag_abs));
        compare_field("trap_min_dist", 64'(seen.trap_min_dist),
                      64'(oldest.want.trap_min_dist));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    view = reset_view();
    repeat (4) @(posedge clk);
    rst    <= 1'b0;
    idling = 1'b1;
    test_reset_view();
    test_register_extremes();
    test_zero_limit_and_bailout();
    test_last_iteration_escape();
    test_deep_orbit();
    test_output_backpressure();
    test_sender_pause();
    test_random_views(10, 50, 1'b1);
    test_random_views(1, 60, 1'b0);
    repeat (100) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never returned", pending_pixels.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
